// ----- sv/mwcm_pkg.sv -----
// Shared constants, register codes and types of the mesh-warp coordinate map unit.
package mwcm_pkg;

    localparam int IMG_W      = 13;
    localparam int GRID_REG_W = 7;
    localparam int PIX_W      = 12;
    localparam int PIX_MAX_W  = 16;
    localparam int VTX_W      = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_GRID   = 64;
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [GRID_REG_W-1:0] RST_GRID_COLS    = 7'd2;
    localparam logic [GRID_REG_W-1:0] RST_GRID_ROWS    = 7'd2;
    localparam logic [IMG_W-1:0]      RST_IMAGE_WIDTH  = 13'd1920;
    localparam logic [IMG_W-1:0]      RST_IMAGE_HEIGHT = 13'd1080;

    localparam logic [VTX_W-1:0] VTX_BIAS = 24'h800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS    = 2'd0,
        CFG_GRID_ROWS    = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    // Command control: par holds the row and column parity of the base vertex.
    typedef struct packed {
        logic       is_map;
        logic       we;
        logic [1:0] par;
    } t_ctl;

endpackage

// ----- sv/mesh_warp_coordinate_map_unit.sv -----
// Top level of the mesh-warp coordinate map unit.
// Usage: the input channel (i_in_valid / o_in_ready) takes one item per transfer.
// An item with i_action low loads one deformed vertex into the mesh table; it
// gives no result. An item with i_action high maps one output pixel and gives
// one result on the output channel (o_out_valid / i_out_ready): the source
// position in Q15.8, bilinearly blended from the four corners of its cell.
// Throughput is one item per cycle while o_in_ready is high, loads and maps
// mixed freely. A map passes the cell divider (COORD_BITS + clog2(MAX_GRID+1) +
// FRAC_BITS stages), the command queue, the bank read and the blend registers.
// Configuration writes (i_cfg_wr_en) take effect at once and belong in idle time.
// Reset clears the pipeline and queues and restores the register defaults; the
// vertex table is not cleared, so every vertex a map uses must be loaded first.
// When the receiver stalls, results collect in an eight-entry queue; the back
// end stops drawing commands, a four-entry command queue fills, and o_in_ready
// drops only when that queue is full.
module mesh_warp_coordinate_map_unit #(
    parameter int MAX_GRID   = mwcm_pkg::DEF_MAX_GRID,
    parameter int COORD_BITS = mwcm_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = mwcm_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [mwcm_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [mwcm_pkg::IMG_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]  i_vertex_col,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]  i_vertex_row,
    input  logic [mwcm_pkg::VTX_W-1:0]       i_vertex_x,
    input  logic [mwcm_pkg::VTX_W-1:0]       i_vertex_y,
    input  logic [mwcm_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [mwcm_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mwcm_pkg::VTX_W-1:0]       o_source_x,
    output logic [mwcm_pkg::VTX_W-1:0]       o_source_y
);
    import mwcm_pkg::*;

    localparam int GW        = $clog2(MAX_GRID + 1);
    localparam int HALF      = MAX_GRID / 2 + 1;
    localparam int RAM_DEPTH = HALF * HALF;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam int NW        = COORD_BITS + GW + FRAC_BITS;
    localparam int CMD_W     = $bits(t_ctl) + 4*AW + 2*(FRAC_BITS+1) + 2*VTX_W;
    localparam int CMD_DEPTH = 4;

    logic [GRID_REG_W-1:0] r_grid_cols;
    logic [GRID_REG_W-1:0] r_grid_rows;
    logic [IMG_W-1:0]      r_image_width;
    logic [IMG_W-1:0]      r_image_height;

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    logic [$clog2(CMD_DEPTH+1)-1:0] q_count;
    t_ctl                  f_ctl;
    logic [3:0][AW-1:0]    f_addr;
    logic [FRAC_BITS:0]    f_fx;
    logic [FRAC_BITS:0]    f_fy;
    logic [2*VTX_W-1:0]    f_data;
    t_ctl                  b_ctl;
    logic [3:0][AW-1:0]    b_addr;
    logic [FRAC_BITS:0]    b_fx;
    logic [FRAC_BITS:0]    b_fy;
    logic [2*VTX_W-1:0]    b_data;
    logic [CMD_W-1:0]      q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols    <= RST_GRID_COLS;
            r_grid_rows    <= RST_GRID_ROWS;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GRID_COLS:    r_grid_cols    <= i_cfg_wdata[GRID_REG_W-1:0];
                CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_wdata[GRID_REG_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    mwcm_front #(
        .MAX_GRID   (MAX_GRID),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .GW         (GW),
        .AW         (AW),
        .NW         (NW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grid_cols    (r_grid_cols),
        .i_grid_rows    (r_grid_rows),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_action       (i_action),
        .i_vertex_col   (i_vertex_col),
        .i_vertex_row   (i_vertex_row),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_push         (push),
        .i_full         (q_full),
        .o_ctl          (f_ctl),
        .o_addr         (f_addr),
        .o_fx           (f_fx),
        .o_fy           (f_fy),
        .o_data         (f_data)
    );

    mwcm_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_addr, f_fx, f_fy, f_data}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {b_ctl, b_addr, b_fx, b_fy, b_data} = q_out;

    mwcm_back #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty || (q_count == '0)),
        .o_pop       (pop),
        .i_ctl       (b_ctl),
        .i_addr      (b_addr),
        .i_fx        (b_fx),
        .i_fy        (b_fy),
        .i_data      (b_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_source_x  (o_source_x),
        .o_source_y  (o_source_y)
    );
endmodule

// ----- sv/mwcm_ram.sv -----
// Generic single-port RAM with registered read data.
module mwcm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1089
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/mwcm_fifo.sv -----
// Small flip-flop queue with occupancy count.
module mwcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

// ----- sv/mwcm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module mwcm_div #(
    parameter int NW = 27,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] n_rem [NW];
    logic [NW-1:0] n_num [NW];
    logic [NW-1:0] n_quo [NW];

    always_comb begin
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          ge;
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                rem_in = '0;
                num_in = i_num;
                quo_in = '0;
            end else begin
                rem_in = r_rem[s-1];
                num_in = r_num[s-1];
                quo_in = r_quo[s-1];
            end
            trial = {rem_in, num_in[NW-1]};
            ge    = (trial >= {1'b0, i_den});
            n_rem[s] = ge ? DW'(trial - {1'b0, i_den}) : DW'(trial);
            n_num[s] = num_in << 1;
            n_quo[s] = {quo_in[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NW; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[NW-1];
endmodule

// ----- sv/mwcm_front.sv -----
// Front end: accepts items, divides pixel positions into cells and forms bank addresses.
module mwcm_front #(
    parameter int MAX_GRID   = 64,
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8,
    parameter int GW         = 7,
    parameter int AW         = 11,
    parameter int NW         = 27
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]   i_grid_cols,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]   i_grid_rows,
    input  logic [mwcm_pkg::IMG_W-1:0]        i_image_width,
    input  logic [mwcm_pkg::IMG_W-1:0]        i_image_height,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]   i_vertex_col,
    input  logic [mwcm_pkg::GRID_REG_W-1:0]   i_vertex_row,
    input  logic [mwcm_pkg::VTX_W-1:0]        i_vertex_x,
    input  logic [mwcm_pkg::VTX_W-1:0]        i_vertex_y,
    input  logic [mwcm_pkg::PIX_W-1:0]        i_pixel_x,
    input  logic [mwcm_pkg::PIX_W-1:0]        i_pixel_y,
    output logic                              o_push,
    input  logic                              i_full,
    output mwcm_pkg::t_ctl                    o_ctl,
    output logic [3:0][AW-1:0]                o_addr,
    output logic [FRAC_BITS:0]                o_fx,
    output logic [FRAC_BITS:0]                o_fy,
    output logic [2*mwcm_pkg::VTX_W-1:0]      o_data
);
    import mwcm_pkg::*;

    localparam int HALF = MAX_GRID / 2 + 1;
    localparam int QW   = NW - FRAC_BITS;

    typedef struct packed {
        logic                 is_map;
        logic                 we;
        logic [GW-1:0]        col;
        logic [GW-1:0]        row;
        logic [2*VTX_W-1:0]   data;
    } t_pl;

    logic [GW-1:0]        gc;
    logic [GW-1:0]        gr;
    logic [IMG_W-1:0]     den_x;
    logic [IMG_W-1:0]     den_y;
    logic [PIX_MAX_W-1:0] px_ext;
    logic [PIX_MAX_W-1:0] py_ext;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                 f_en;

    logic                 r_s0_v;
    t_pl                  r_s0_pl;
    logic [NW-1:0]        r_num_x;
    logic [NW-1:0]        r_num_y;
    logic                 r_v  [NW];
    t_pl                  r_pl [NW];
    logic [NW-1:0]        quo_x;
    logic [NW-1:0]        quo_y;

    logic [GW-1:0]        cx;
    logic [GW-1:0]        cy;
    logic [FRAC_BITS:0]   fx;
    logic [FRAC_BITS:0]   fy;
    logic [GW-1:0]        base_c;
    logic [GW-1:0]        base_r;
    logic [3:0][AW-1:0]   addr_n;

    logic                 r_a_v;
    t_ctl                 r_a_ctl;
    logic [3:0][AW-1:0]   r_a_addr;
    logic [FRAC_BITS:0]   r_a_fx;
    logic [FRAC_BITS:0]   r_a_fy;
    logic [2*VTX_W-1:0]   r_a_data;

    always_comb begin
        if (i_grid_cols < 2) begin
            gc = GW'(2);
        end else if (i_grid_cols > MAX_GRID) begin
            gc = GW'(MAX_GRID);
        end else begin
            gc = GW'(i_grid_cols);
        end
        if (i_grid_rows < 2) begin
            gr = GW'(2);
        end else if (i_grid_rows > MAX_GRID) begin
            gr = GW'(MAX_GRID);
        end else begin
            gr = GW'(i_grid_rows);
        end
    end

    assign den_x  = (i_image_width  >= IMG_W'(2)) ? i_image_width  - IMG_W'(1) : IMG_W'(1);
    assign den_y  = (i_image_height >= IMG_W'(2)) ? i_image_height - IMG_W'(1) : IMG_W'(1);
    assign px_ext = {{(PIX_MAX_W-PIX_W){1'b0}}, i_pixel_x};
    assign py_ext = {{(PIX_MAX_W-PIX_W){1'b0}}, i_pixel_y};
    assign px     = px_ext[COORD_BITS-1:0];
    assign py     = py_ext[COORD_BITS-1:0];

    // The whole front advances together; it holds only when the queue refuses a transfer.
    assign f_en    = !r_a_v || !i_full;
    assign o_ready = f_en;
    assign o_push  = r_a_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            for (int s = 0; s < NW; s++) begin
                r_v[s] <= 1'b0;
            end
            r_a_v <= 1'b0;
        end else if (f_en) begin
            r_s0_v <= i_valid;
            r_v[0] <= r_s0_v;
            for (int s = 1; s < NW; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_a_v <= r_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_s0_pl.is_map <= i_action;
            r_s0_pl.we     <= (i_vertex_col <= MAX_GRID) && (i_vertex_row <= MAX_GRID);
            r_s0_pl.col    <= GW'(i_vertex_col);
            r_s0_pl.row    <= GW'(i_vertex_row);
            r_s0_pl.data   <= {i_vertex_x, i_vertex_y};
            r_num_x        <= (NW'(px) * NW'(gc)) << FRAC_BITS;
            r_num_y        <= (NW'(py) * NW'(gr)) << FRAC_BITS;
            r_pl[0]        <= r_s0_pl;
            for (int s = 1; s < NW; s++) begin
                r_pl[s] <= r_pl[s-1];
            end
            r_a_ctl        <= '{is_map: r_pl[NW-1].is_map,
                                we:     !r_pl[NW-1].is_map && r_pl[NW-1].we,
                                par:    {base_r[0], base_c[0]}};
            r_a_addr       <= addr_n;
            r_a_fx         <= fx;
            r_a_fy         <= fy;
            r_a_data       <= r_pl[NW-1].data;
        end
    end

    mwcm_div #(.NW(NW), .DW(IMG_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (f_en),
        .i_num (r_num_x),
        .i_den (den_x),
        .o_quo (quo_x)
    );

    mwcm_div #(.NW(NW), .DW(IMG_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (f_en),
        .i_num (r_num_y),
        .i_den (den_y),
        .o_quo (quo_y)
    );

    // A position on or past the last cell boundary lands in the last cell at full weight.
    always_comb begin
        if (quo_x[NW-1:FRAC_BITS] >= QW'(gc)) begin
            cx = gc - 1'b1;
            fx = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            cx = GW'(quo_x[NW-1:FRAC_BITS]);
            fx = {1'b0, quo_x[FRAC_BITS-1:0]};
        end
        if (quo_y[NW-1:FRAC_BITS] >= QW'(gr)) begin
            cy = gr - 1'b1;
            fy = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            cy = GW'(quo_y[NW-1:FRAC_BITS]);
            fy = {1'b0, quo_y[FRAC_BITS-1:0]};
        end
    end

    assign base_c = r_pl[NW-1].is_map ? cx : r_pl[NW-1].col;
    assign base_r = r_pl[NW-1].is_map ? cy : r_pl[NW-1].row;

    // Vertices are spread over four banks by row and column parity, so the four
    // corners of a cell always sit in different banks.
    always_comb begin
        logic [GW:0] rr;
        logic [GW:0] cc;
        logic [1:0]  bb;
        for (int b = 0; b < 4; b++) begin
            bb = 2'(b);
            rr = {1'b0, base_r} + (GW+1)'(base_r[0] ^ bb[1]);
            cc = {1'b0, base_c} + (GW+1)'(base_c[0] ^ bb[0]);
            addr_n[b] = AW'(32'(rr >> 1) * HALF + 32'(cc >> 1));
        end
    end

    assign o_ctl  = r_a_ctl;
    assign o_addr = r_a_addr;
    assign o_fx   = r_a_fx;
    assign o_fy   = r_a_fy;
    assign o_data = r_a_data;
endmodule

// ----- sv/mwcm_back.sv -----
// Back end: vertex banks, bilinear blend and the result queue.
module mwcm_back #(
    parameter int FRAC_BITS = 8,
    parameter int AW        = 11,
    parameter int RAM_DEPTH = 1089
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  mwcm_pkg::t_ctl                i_ctl,
    input  logic [3:0][AW-1:0]            i_addr,
    input  logic [FRAC_BITS:0]            i_fx,
    input  logic [FRAC_BITS:0]            i_fy,
    input  logic [2*mwcm_pkg::VTX_W-1:0]  i_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mwcm_pkg::VTX_W-1:0]    o_source_x,
    output logic [mwcm_pkg::VTX_W-1:0]    o_source_y
);
    import mwcm_pkg::*;

    localparam int WW        = 2*FRAC_BITS + 2;
    localparam int PW        = VTX_W + WW;
    localparam int SW        = PW + 2;
    localparam int OUT_DEPTH = 8;
    localparam int OCW       = $clog2(OUT_DEPTH+1);
    localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [SW-1:0]      HALF_LSB = SW'(1) << (2*FRAC_BITS - 1);

    logic [2*VTX_W-1:0] rd [4];
    logic [OCW-1:0]     out_count;
    logic               out_empty;
    logic               out_full;
    logic [OCW+1:0]     credit;

    logic               r_b1_v;
    logic [1:0]         r_b1_par;
    logic [FRAC_BITS:0] r_b1_fx;
    logic [FRAC_BITS:0] r_b1_fy;

    logic [FRAC_BITS:0] gx;
    logic [FRAC_BITS:0] gy;
    logic [VTX_W-1:0]   n_cx [4];
    logic [VTX_W-1:0]   n_cy [4];
    logic [WW-1:0]      n_w  [4];

    logic               r_b2_v;
    logic [VTX_W-1:0]   r_b2_cx [4];
    logic [VTX_W-1:0]   r_b2_cy [4];
    logic [WW-1:0]      r_b2_w  [4];

    logic               r_b3_v;
    logic [PW-1:0]      r_b3_px [4];
    logic [PW-1:0]      r_b3_py [4];

    logic [SW-1:0]      acc_x;
    logic [SW-1:0]      acc_y;
    logic [VTX_W-1:0]   res_x;
    logic [VTX_W-1:0]   res_y;
    logic [2*VTX_W-1:0] out_data;

    // Only as many items leave the queue as the result queue can still take.
    assign credit = (OCW+2)'(out_count) + (OCW+2)'(r_b1_v) + (OCW+2)'(r_b2_v)
                  + (OCW+2)'(r_b3_v);
    assign o_pop  = !i_q_empty && (credit < (OCW+2)'(OUT_DEPTH));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        mwcm_ram #(.WIDTH(2*VTX_W), .DEPTH(RAM_DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (o_pop && i_ctl.we && (i_ctl.par == 2'(b))),
            .i_addr  (i_addr[b]),
            .i_wdata (i_data),
            .o_rdata (rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else begin
            r_b1_v <= o_pop && i_ctl.is_map;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
        end
    end

    assign gx = ONE - r_b1_fx;
    assign gy = ONE - r_b1_fy;

    // Corner order: base, one column on, one row on, diagonal.
    always_comb begin
        logic [1:0] sel;
        for (int k = 0; k < 4; k++) begin
            sel     = r_b1_par ^ 2'(k);
            n_cx[k] = rd[sel][2*VTX_W-1:VTX_W] ^ VTX_BIAS;
            n_cy[k] = rd[sel][VTX_W-1:0] ^ VTX_BIAS;
        end
        n_w[0] = WW'(gx) * WW'(gy);
        n_w[1] = WW'(r_b1_fx) * WW'(gy);
        n_w[2] = WW'(gx) * WW'(r_b1_fy);
        n_w[3] = WW'(r_b1_fx) * WW'(r_b1_fy);
    end

    always_ff @(posedge i_clk) begin
        r_b1_par <= i_ctl.par;
        r_b1_fx  <= i_fx;
        r_b1_fy  <= i_fy;
        for (int k = 0; k < 4; k++) begin
            r_b2_cx[k] <= n_cx[k];
            r_b2_cy[k] <= n_cy[k];
            r_b2_w[k]  <= n_w[k];
            r_b3_px[k] <= PW'(r_b2_cx[k]) * PW'(r_b2_w[k]);
            r_b3_py[k] <= PW'(r_b2_cy[k]) * PW'(r_b2_w[k]);
        end
    end

    assign acc_x = SW'(r_b3_px[0]) + SW'(r_b3_px[1]) + SW'(r_b3_px[2]) + SW'(r_b3_px[3])
                 + HALF_LSB;
    assign acc_y = SW'(r_b3_py[0]) + SW'(r_b3_py[1]) + SW'(r_b3_py[2]) + SW'(r_b3_py[3])
                 + HALF_LSB;
    assign res_x = acc_x[2*FRAC_BITS +: VTX_W] ^ VTX_BIAS;
    assign res_y = acc_y[2*FRAC_BITS +: VTX_W] ^ VTX_BIAS;

    mwcm_fifo #(.WIDTH(2*VTX_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b3_v),
        .i_data  ({res_x, res_y}),
        .i_pop   (o_out_valid && i_out_ready),
        .o_data  (out_data),
        .o_full  (out_full),
        .o_empty (out_empty),
        .o_count (out_count)
    );

    assign o_out_valid = !out_empty && !(out_full && 1'b0);
    assign o_source_x  = out_data[2*VTX_W-1:VTX_W];
    assign o_source_y  = out_data[VTX_W-1:0];
endmodule

// ----- sv/mwcm_checker.sv -----
// Port-level checks of the mesh-warp coordinate map unit, bound to the top level.
module mwcm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [mwcm_pkg::VTX_W-1:0] o_source_x,
    input logic [mwcm_pkg::VTX_W-1:0] o_source_y
);
    // A result that is not taken stays offered with the same value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_source_x) && $stable(o_source_y))
        else $error("stalled result changed or vanished");

    // Reset empties the result queue.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Reset empties the command queue, so input is taken at once.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // An item taken after reset cannot yet have crossed the pipeline.
    a_rst_latency: assert property (@(posedge i_clk)
        $past(!i_rst_n, 2) |-> !o_out_valid)
        else $error("result appeared too soon after reset");
endmodule

bind mesh_warp_coordinate_map_unit mwcm_checker u_mwcm_checker (.*);
